>>> rtl/core/ove_pkg.sv
// ove_pkg: sizes, opcodes, status codes and shared types for the ordered vector engine.
// No dependencies.
package ove_pkg;

  // vector geometry
  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;

  localparam logic [3:0] OP_CLEAR   = 4'd0;
  localparam logic [3:0] OP_INSERT  = 4'd1;
  localparam logic [3:0] OP_PUSH    = 4'd2;
  localparam logic [3:0] OP_ERASE   = 4'd3;
  localparam logic [3:0] OP_POP     = 4'd4;
  localparam logic [3:0] OP_READ    = 4'd5;
  localparam logic [3:0] OP_FIND    = 4'd6;
  localparam logic [3:0] OP_REMOVE  = 4'd7;
  localparam logic [3:0] OP_UNIQUE  = 4'd8;
  localparam logic [3:0] OP_SORTUP  = 4'd9;
  localparam logic [3:0] OP_SORTDN  = 4'd10;
  localparam logic [3:0] OP_REVERSE = 4'd11;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // per-cycle command broadcast to every cell
  localparam logic [2:0] CMD_HOLD   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1; // shift up at and above pos, write pos
  localparam logic [2:0] CMD_ERASE  = 3'd2; // shift down at and above pos
  localparam logic [2:0] CMD_ODD    = 3'd3; // compare-swap pairs starting at odd cells
  localparam logic [2:0] CMD_EVEN   = 3'd4; // compare-swap pairs starting at even cells
  localparam logic [2:0] CMD_ROTATE = 3'd5; // shift [pos..last) down by one, write new_value at last-1

  typedef struct packed {
    logic [2:0] cmd;
    logic       descending;
    logic       signed_cmp;
  } ove_cmd_t;

endpackage

>>> rtl/core/ove_cell.sv
// ove_cell: one storage slot of the vector with its neighbor mux and
// compare-swap decision. Depends on ove_pkg.
module ove_cell #(
  parameter int ELEM_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  ove_pkg::ove_cmd_t     ctl,
  input  logic [IDX_W-1:0]      my_index,
  input  logic [IDX_W-1:0]      pos,      // insert/erase/rotate start
  input  logic [IDX_W:0]        last,     // rotate/sort bound (exclusive)
  input  logic [ELEM_WIDTH-1:0] new_value,
  input  logic [ELEM_WIDTH-1:0] below,    // neighbor at index-1
  input  logic [ELEM_WIDTH-1:0] above,    // neighbor at index+1
  input  logic                  below_swap, // pair (i-1,i) swaps
  output logic                  my_swap,    // pair (i,i+1) swaps
  output logic [ELEM_WIDTH-1:0] data
);

  logic [ELEM_WIDTH-1:0] a_k, b_k;
  logic                  gt, lt, lead, in_pair;
  logic [ELEM_WIDTH-1:0] data_next;
  logic [IDX_W:0]        idx1;

  assign idx1 = {1'b0, my_index} + 1'b1;

  // ordering with optional sign flip
  always_comb begin
    a_k = data;
    b_k = above;
    if (ctl.signed_cmp) begin
      a_k[ELEM_WIDTH-1] = ~a_k[ELEM_WIDTH-1];
      b_k[ELEM_WIDTH-1] = ~b_k[ELEM_WIDTH-1];
    end
    gt = a_k > b_k;
    lt = a_k < b_k;
    lead = (ctl.cmd == ove_pkg::CMD_ODD) ? my_index[0] : ~my_index[0];
    in_pair = (idx1 < last);
    my_swap = (ctl.cmd == ove_pkg::CMD_ODD || ctl.cmd == ove_pkg::CMD_EVEN) &&
              lead && in_pair && (ctl.descending ? lt : gt);
  end

  always_comb begin
    data_next = data;
    case (ctl.cmd)
      ove_pkg::CMD_INSERT: begin
        if (my_index == pos) data_next = new_value;
        else if (my_index > pos) data_next = below;
      end
      ove_pkg::CMD_ERASE:
        if (my_index >= pos) data_next = above;
      ove_pkg::CMD_ODD, ove_pkg::CMD_EVEN: begin
        if (my_swap) data_next = above;
        else if (below_swap) data_next = below;
      end
      ove_pkg::CMD_ROTATE: begin
        if (my_index >= pos && idx1 < last) data_next = above;
        else if (idx1 == last) data_next = new_value;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> rtl/core/ove_chain.sv
// ove_chain: row of ove_cell slots wired to their neighbors.
// Depends on ove_pkg and ove_cell.
module ove_chain #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int IDX_W      = 4
) (
  input  logic                                 clk,
  input  ove_pkg::ove_cmd_t                    ctl,
  input  logic [IDX_W-1:0]                     pos,
  input  logic [IDX_W:0]                       last,
  input  logic [ELEM_WIDTH-1:0]                new_value,
  output logic [CAPACITY-1:0][ELEM_WIDTH-1:0]  cells
);

  logic [CAPACITY-1:0] swp;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] below_d, above_d;
    logic                  below_s;
    if (g == 0) begin : g_lo
      assign below_d = '0;
      assign below_s = 1'b0;
    end else begin : g_mid
      assign below_d = cells[g-1];
      assign below_s = swp[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi
      assign above_d = '0;
    end else begin : g_nhi
      assign above_d = cells[g+1];
    end
    ove_cell #(.ELEM_WIDTH(ELEM_WIDTH), .IDX_W(IDX_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .my_index  (IDX_W'(g)),
      .pos       (pos),
      .last      (last),
      .new_value (new_value),
      .below     (below_d),
      .above     (above_d),
      .below_swap(below_s),
      .my_swap   (swp[g]),
      .data      (cells[g])
    );
  end

endmodule

>>> rtl/core/ordered_vector_engine_top.sv
// ordered_vector_engine_top: sequencer, handshake and result register around
// the cell chain. Depends on ove_pkg and ove_chain.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: opcode[3:0] position[8:4] value[40:9]
//  m_axis    | out       | tdata: status, index_valid, result_index, read_data,
//            |           |        count, is_empty, is_full
//  cfg       | in        | compare_signed
//
// An item is accepted in idle, runs its steps, then waits in the output state
// until taken. Simple ops run one step; find runs one step per entry scanned from
// the given position. Sort runs count+1 odd/even passes; remove and unique run count+1
// steps, each erasing a match or advancing; reverse runs max(count,1) steps.
// One item is in work at a time; the result register holds while m_axis
// stalls. rst is synchronous and clears count, control and compare_signed.
module ordered_vector_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // opcode, position, value, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status, index_valid, result_index,
                                     // read_data, count, is_empty, is_full, pad
  input  logic        cfg_wen,
  input  logic        cfg_wdata      // compare_signed
);

  localparam int CAPACITY   = ove_pkg::CAPACITY;
  localparam int ELEM_WIDTH = ove_pkg::ELEM_WIDTH;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = IDX_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state;
  logic        compare_signed;
  logic [CW-1:0] count;
  logic [3:0]  op;
  logic [4:0]  pos_in;
  logic [ELEM_WIDTH-1:0] key;
  logic [CW-1:0] scan;     // scan pointer / step counter
  logic [CW-1:0] hi;       // end bound for reverse
  logic [CAPACITY-1:0][ELEM_WIDTH-1:0] cells;

  // result fields
  logic [1:0]  r_status;
  logic        r_ivalid;
  logic [3:0]  r_index;
  logic [31:0] r_data;

  ove_pkg::ove_cmd_t ctl;
  logic [IDX_W-1:0]  c_pos;
  logic [CW-1:0]     c_last;
  logic [ELEM_WIDTH-1:0] c_val;

  logic [ELEM_WIDTH-1:0] cur, prev;
  logic [IDX_W-1:0] scan_i;
  assign scan_i = scan[IDX_W-1:0];
  assign cur  = cells[scan_i];
  assign prev = cells[scan_i - 1'b1];

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) compare_signed <= 1'b0;
    else if (cfg_wen) compare_signed <= cfg_wdata;
  end

  // chain command for this cycle
  always_comb begin
    ctl.cmd = ove_pkg::CMD_HOLD;
    ctl.descending = (op == ove_pkg::OP_SORTDN);
    ctl.signed_cmp = compare_signed;
    c_pos  = scan_i;
    c_last = count;
    c_val  = key;
    if (state == S_RUN) begin
      case (op)
        ove_pkg::OP_INSERT, ove_pkg::OP_PUSH:
          if (count < CW'(CAPACITY)) begin
            ctl.cmd = ove_pkg::CMD_INSERT;
            c_pos = (op == ove_pkg::OP_PUSH || {1'b0, pos_in} > 6'(count)) ?
                    count[IDX_W-1:0] : pos_in[IDX_W-1:0];
          end
        ove_pkg::OP_ERASE:
          if (6'(pos_in) < 6'(count)) begin
            ctl.cmd = ove_pkg::CMD_ERASE;
            c_pos = pos_in[IDX_W-1:0];
          end
        ove_pkg::OP_REMOVE:
          if (scan < count && cur == key) ctl.cmd = ove_pkg::CMD_ERASE;
        ove_pkg::OP_UNIQUE:
          if (scan < count && scan != '0 && cur == prev) ctl.cmd = ove_pkg::CMD_ERASE;
        ove_pkg::OP_SORTUP, ove_pkg::OP_SORTDN:
          ctl.cmd = scan[0] ? ove_pkg::CMD_ODD : ove_pkg::CMD_EVEN;
        ove_pkg::OP_REVERSE:
          if (scan + 1'b1 < hi) begin
            // move last element to slot scan: rotate [scan..hi) up by one
            ctl.cmd = ove_pkg::CMD_INSERT;
            c_val = cells[hi[IDX_W-1:0] - 1'b1];
          end
        default: ctl.cmd = ove_pkg::CMD_HOLD;
      endcase
    end
  end

  ove_chain #(.CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH), .IDX_W(IDX_W)) u_chain (
    .clk(clk), .ctl(ctl), .pos(c_pos), .last(c_last), .new_value(c_val), .cells(cells)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op     <= s_axis_tdata[3:0];
          pos_in <= s_axis_tdata[8:4];
          key    <= ELEM_WIDTH'(s_axis_tdata[40:9]);
          scan   <= (s_axis_tdata[3:0] == ove_pkg::OP_FIND) ?
                    CW'(s_axis_tdata[8:4]) : '0;
          hi     <= count;
          r_status <= ove_pkg::ST_OK;
          r_ivalid <= 1'b0;
          r_index  <= '0;
          r_data   <= '0;
          state  <= S_RUN;
        end
        S_RUN: begin
          state <= S_OUT;
          case (op)
            ove_pkg::OP_CLEAR: count <= '0;
            ove_pkg::OP_INSERT, ove_pkg::OP_PUSH:
              if (count >= CW'(CAPACITY)) r_status <= ove_pkg::ST_FULL;
              else begin
                count <= count + 1'b1;
                r_ivalid <= 1'b1;
                r_index <= 4'(c_pos);
              end
            ove_pkg::OP_ERASE:
              if (6'(pos_in) >= 6'(count)) r_status <= ove_pkg::ST_RANGE;
              else begin
                count <= count - 1'b1;
                if (6'(pos_in) + 6'd1 < 6'(count)) begin
                  r_ivalid <= 1'b1;
                  r_index <= pos_in[3:0];
                end
              end
            ove_pkg::OP_POP: if (count != '0) count <= count - 1'b1;
            ove_pkg::OP_READ:
              if (6'(pos_in) >= 6'(count)) r_status <= ove_pkg::ST_RANGE;
              else begin
                r_data <= 32'(cells[pos_in[IDX_W-1:0]]);
                r_ivalid <= 1'b1;
                r_index <= pos_in[3:0];
              end
            ove_pkg::OP_FIND:
              if (count == '0) r_status <= ove_pkg::ST_NOTFOUND;
              else if (6'(pos_in) >= 6'(count)) r_status <= ove_pkg::ST_RANGE;
              else if (cur == key) begin
                r_ivalid <= 1'b1;
                r_index <= 4'(scan);
              end else if (scan + 1'b1 >= count) r_status <= ove_pkg::ST_NOTFOUND;
              else begin
                scan <= scan + 1'b1;
                state <= S_RUN;
              end
            ove_pkg::OP_REMOVE, ove_pkg::OP_UNIQUE:
              if (scan < count) begin
                state <= S_RUN;
                if (ctl.cmd == ove_pkg::CMD_ERASE) count <= count - 1'b1;
                else scan <= scan + 1'b1;
              end
            ove_pkg::OP_SORTUP, ove_pkg::OP_SORTDN:
              if (scan < count) begin
                scan <= scan + 1'b1;
                state <= S_RUN;
              end
            ove_pkg::OP_REVERSE:
              if (scan + 1'b1 < hi) begin
                scan <= scan + 1'b1;
                state <= S_RUN;
              end
            default: ;
          endcase
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result packing
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[1:0]   = r_status;
    m_axis_tdata[2]     = r_ivalid;
    m_axis_tdata[6:3]   = r_index;
    m_axis_tdata[38:7]  = r_data;
    m_axis_tdata[43:39] = 5'(count);
    m_axis_tdata[44]    = (count == '0);
    m_axis_tdata[45]    = (count >= CW'(CAPACITY));
  end

endmodule

>>> verif/testbench.sv
// testbench: self-checking regression for ordered_vector_engine_top.
// Depends on ove_pkg and the RTL of the engine; holds its own vector predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int CAP = 16;

  // field order follows m_axis_tdata from the top bit down
  typedef struct packed {
    logic        is_full;
    logic        is_empty;
    logic [4:0]  count;
    logic [31:0] read_data;
    logic [3:0]  result_index;
    logic        index_valid;
    logic [1:0]  status;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // opcode, position, value, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // status .. is_full, pad
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;    // compare_signed

  // predictor state
  logic [31:0] model_elems [CAP];
  int          model_count;
  logic        model_signed;
  vec_result_t pending_results [$];

  int error_count;
  int sent_count;
  int checked_count;
  bit rx_hold;        // forces a long receiver stall

  ordered_vector_engine_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 30)
      $display("ERROR t=%0t %s got %h want %h", $realtime, what, got, want);
  endtask

  // true when a sorts strictly after b under the current ordering
  function automatic bit elem_after(logic [31:0] a, logic [31:0] b);
    if (model_signed) return $signed(a) > $signed(b);
    return a > b;
  endfunction

  function automatic vec_result_t predict_vector_op(logic [3:0] op, logic [4:0] pos_in,
                                                    logic [31:0] val);
    vec_result_t r;
    int n, p, j;
    logic [31:0] a, b, t;
    r = '0;
    n = model_count;
    p = int'(pos_in);
    case (op)
      ove_pkg::OP_CLEAR: model_count = 0;
      ove_pkg::OP_INSERT, ove_pkg::OP_PUSH: begin
        if (op == ove_pkg::OP_PUSH || p > n) p = n;
        if (n >= CAP) r.status = ove_pkg::ST_FULL;
        else begin
          for (int i = n; i > p; i--) model_elems[i] = model_elems[i-1];
          model_elems[p] = val;
          model_count = n + 1;
          r.index_valid = 1'b1;
          r.result_index = 4'(p);
        end
      end
      ove_pkg::OP_ERASE: begin
        if (p >= n) r.status = ove_pkg::ST_RANGE;
        else begin
          for (int i = p; i + 1 < n; i++) model_elems[i] = model_elems[i+1];
          model_count = n - 1;
          if (p + 1 < n) begin
            r.index_valid = 1'b1;
            r.result_index = 4'(p);
          end
        end
      end
      ove_pkg::OP_POP: if (n > 0) model_count = n - 1;
      ove_pkg::OP_READ: begin
        if (p >= n) r.status = ove_pkg::ST_RANGE;
        else begin
          r.read_data = model_elems[p];
          r.index_valid = 1'b1;
          r.result_index = 4'(p);
        end
      end
      ove_pkg::OP_FIND: begin
        if (n == 0) r.status = ove_pkg::ST_NOTFOUND;
        else if (p >= n) r.status = ove_pkg::ST_RANGE;
        else begin
          r.status = ove_pkg::ST_NOTFOUND;
          for (int i = p; i < n; i++)
            if (model_elems[i] == val) begin
              r.status = ove_pkg::ST_OK;
              r.index_valid = 1'b1;
              r.result_index = 4'(i);
              break;
            end
        end
      end
      ove_pkg::OP_REMOVE: begin
        j = 0;
        for (int i = 0; i < n; i++)
          if (model_elems[i] != val) model_elems[j++] = model_elems[i];
        model_count = j;
      end
      ove_pkg::OP_UNIQUE: if (n > 0) begin
        j = 1;
        for (int i = 1; i < n; i++)
          if (model_elems[i] != model_elems[j-1]) model_elems[j++] = model_elems[i];
        model_count = j;
      end
      ove_pkg::OP_SORTUP, ove_pkg::OP_SORTDN: begin
        for (int k = n; k > 1; k--)
          for (int i = 0; i + 1 < k; i++) begin
            a = model_elems[i];
            b = model_elems[i+1];
            if (op == ove_pkg::OP_SORTUP ? elem_after(a, b) : elem_after(b, a)) begin
              model_elems[i] = b;
              model_elems[i+1] = a;
            end
          end
      end
      ove_pkg::OP_REVERSE: begin
        j = n;
        for (int i = 0; i + 1 < j; i++) begin
          t = model_elems[i];
          model_elems[i] = model_elems[j-1];
          model_elems[j-1] = t;
          j--;
        end
      end
      default: ;
    endcase
    r.count = 5'(model_count);
    r.is_empty = (model_count == 0);
    r.is_full = (model_count >= CAP);
    return r;
  endfunction

  // send one transaction, predicting its result when accepted
  task automatic send_op(input logic [3:0] op, input logic [4:0] pos,
                         input logic [31:0] val, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, val, pos, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(predict_vector_op(op, pos, val));
    sent_count++;
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_compare_mode(input logic mode);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_wen <= 1'b0;
    model_signed = mode;
    @(posedge clk);
  endtask

  // receiver: random stall per result, or a long hold when asked
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    vec_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[45:0];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got[31:0], 32'h0);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.index_valid != want.index_valid)
          report_mismatch("index_valid", 32'(got.index_valid), 32'(want.index_valid));
        if (got.result_index != want.result_index)
          report_mismatch("result_index", 32'(got.result_index),
                          32'(want.result_index));
        if (got.read_data != want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.count != want.count)
          report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.is_empty != want.is_empty)
          report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.is_full != want.is_full)
          report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
      end
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 3);   // small pool makes duplicates
      default: return $urandom();
    endcase
  endfunction

  // directed: extremes, each opcode, and the named corner cases
  task automatic test_directed();
    send_op(ove_pkg::OP_POP, 0, 0);                 // pop when empty
    send_op(ove_pkg::OP_FIND, 0, 0);                // find in empty vector
    send_op(ove_pkg::OP_READ, 0, 0);                // read out of range
    send_op(ove_pkg::OP_PUSH, 31, 32'hFFFF_FFFF);
    send_op(ove_pkg::OP_INSERT, 0, 32'h8000_0000);
    send_op(ove_pkg::OP_INSERT, 31, 32'h7FFF_FFFF); // past count: append
    send_op(ove_pkg::OP_INSERT, 1, 32'h0);
    send_op(ove_pkg::OP_READ, 1, 0);
    send_op(ove_pkg::OP_FIND, 1, 32'h7FFF_FFFF);
    send_op(ove_pkg::OP_FIND, 0, 32'h1234_5678);    // no match
    send_op(ove_pkg::OP_FIND, 9, 0);                // start past count
    send_op(ove_pkg::OP_SORTUP, 0, 0);
    send_op(ove_pkg::OP_SORTDN, 0, 0);
    send_op(ove_pkg::OP_REVERSE, 0, 0);
    send_op(ove_pkg::OP_ERASE, 3, 0);               // erase last
    send_op(ove_pkg::OP_ERASE, 10, 0);              // erase out of range
    send_op(ove_pkg::OP_ERASE, 0, 0);
    send_op(ove_pkg::OP_PUSH, 0, 32'h0);
    send_op(ove_pkg::OP_PUSH, 0, 32'h0);
    send_op(ove_pkg::OP_UNIQUE, 0, 0);
    send_op(ove_pkg::OP_REMOVE, 0, 32'h0);
    send_op(4'd12, 0, 0);                           // unused opcodes
    send_op(4'd15, 5'd31, 32'hFFFF_FFFF);
    send_op(ove_pkg::OP_CLEAR, 0, 0);
    wait_drained();
  endtask

  // fill to capacity, refused insert, then full-size ops
  task automatic test_full();
    for (int i = 0; i < CAP; i++) send_op(ove_pkg::OP_PUSH, 0, rand_elem());
    send_op(ove_pkg::OP_INSERT, 0, 32'hDEAD_BEEF);
    send_op(ove_pkg::OP_PUSH, 0, 32'h1);
    send_op(ove_pkg::OP_READ, 15, 0);
    send_op(ove_pkg::OP_FIND, 15, 0);
    send_op(ove_pkg::OP_SORTUP, 0, 0);
    send_op(ove_pkg::OP_REVERSE, 0, 0);
    send_op(ove_pkg::OP_SORTDN, 0, 0);
    send_op(ove_pkg::OP_UNIQUE, 0, 0);
    send_op(ove_pkg::OP_CLEAR, 0, 0);
  endtask

  function automatic logic [3:0] rand_op();
    int k;
    k = $urandom_range(0, 99);
    if (k < 22) return ove_pkg::OP_PUSH;
    if (k < 34) return ove_pkg::OP_INSERT;
    if (k < 42) return ove_pkg::OP_ERASE;
    if (k < 48) return ove_pkg::OP_POP;
    if (k < 60) return ove_pkg::OP_READ;
    if (k < 70) return ove_pkg::OP_FIND;
    if (k < 75) return ove_pkg::OP_REMOVE;
    if (k < 80) return ove_pkg::OP_UNIQUE;
    if (k < 86) return ove_pkg::OP_SORTUP;
    if (k < 91) return ove_pkg::OP_SORTDN;
    if (k < 96) return ove_pkg::OP_REVERSE;
    if (k < 98) return ove_pkg::OP_CLEAR;
    return 4'($urandom_range(12, 15));
  endfunction

  task automatic test_random(input int items);
    for (int i = 0; i < items; i++)
      send_op(rand_op(), 5'($urandom_range(0, 31) < 24 ? $urandom_range(0, 16)
                                                       : $urandom_range(0, 31)),
              rand_elem());
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_op(rand_op(), 5'($urandom_range(0, 16)),
                                           rand_elem(), 1);
    join
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    model_count = 0;
    model_signed = 1'b0;
    foreach (model_elems[i]) model_elems[i] = '0;
    @(posedge clk);
    test_directed();
    test_full();
    write_compare_mode(1'b1);
    test_full();
    test_random(600);
    test_backpressure();
    write_compare_mode(1'b0);
    test_random(600);
    write_compare_mode(1'b1);
    test_random(600);
    write_compare_mode(1'b0);
    wait_drained();
    $display("Covered %0d transactions (%0d checked), all opcodes, both orderings,",
             sent_count, checked_count);
    $display("full/empty edges, out-of-range positions and long output stalls.");
    if (error_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
